// File: src/srs_pkg.sv
// Shared types, constants and codes for the selective-repeat sender.
package srs_pkg;

    localparam int MAX_PACKETS = 256;
    localparam int MAX_WINDOW  = 8;
    localparam int OUT_LIMIT   = 8;
    localparam int W_LIMIT     = (MAX_WINDOW < OUT_LIMIT) ? MAX_WINDOW : OUT_LIMIT;

    localparam int PKT_W  = 9;
    localparam int TOT_W  = 9;
    localparam int WSZ_W  = 4;
    localparam int TMO_W  = 8;
    localparam int IDX_W  = $clog2(MAX_PACKETS + 1);
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W  = $clog2(W_LIMIT + 1);

    localparam logic [1:0] CFG_PACKET_TOTAL  = 2'd0;
    localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_ACK   = 2'd1,
        REQ_NACK  = 2'd2,
        REQ_START = 2'd3
    } t_req_e;

    localparam logic [1:0] EV_FIRST   = 2'd0;
    localparam logic [1:0] EV_TIMEOUT = 2'd1;
    localparam logic [1:0] EV_NACK    = 2'd2;
    localparam logic [1:0] EV_DONE    = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [PKT_W-1:0] packet_number;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       event_kind;
        logic [PKT_W-1:0] packet_id;
        logic             last_of_run;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic latch;
        logic start_run;
        logic scan_init;
        logic scan_step;
        logic nack_send;
        logic mark_ack;
        logic slide_step;
        logic admit_step;
        logic emit_done;
        logic finish;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_req_e req;
        logic   running;
        logic   ref_ok;
        logic   idx_is_base;
        logic   scan_more;
        logic   slide_more;
        logic   admit_more;
        logic   all_done;
        logic   hold_valid;
        logic   out_free;
    } t_status;

endpackage

// File: src/srs_ctrl.sv
// Controller state machine that sequences one request beat through the datapath.
module srs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  srs_pkg::t_status i_status,
    output logic             o_in_ready,
    output srs_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_SLIDE  = 7'b0001000,
        ST_ADMIT  = 7'b0010000,
        ST_DONE   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } t_state_e;

    t_state_e r_state;
    t_state_e n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.req == srs_pkg::REQ_START) begin
                    o_cmd.start_run = 1'b1;
                    n_state         = ST_ADMIT;
                end else if (!i_status.running) begin
                    n_state = ST_FINISH;
                end else if (i_status.req == srs_pkg::REQ_TICK) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SCAN;
                end else if (!i_status.ref_ok) begin
                    n_state = ST_FINISH;
                end else if (i_status.req == srs_pkg::REQ_NACK) begin
                    if (i_status.out_free) begin
                        o_cmd.nack_send = 1'b1;
                        n_state         = ST_FINISH;
                    end
                end else begin
                    o_cmd.mark_ack = 1'b1;
                    n_state        = i_status.idx_is_base ? ST_SLIDE : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (!i_status.scan_more) begin
                    n_state = ST_FINISH;
                end else if (i_status.out_free) begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_SLIDE: begin
                if (i_status.slide_more) begin
                    o_cmd.slide_step = 1'b1;
                end else begin
                    n_state = ST_ADMIT;
                end
            end
            ST_ADMIT: begin
                if (i_status.admit_more) begin
                    if (i_status.out_free) begin
                        o_cmd.admit_step = 1'b1;
                    end
                end else if (i_status.req == srs_pkg::REQ_ACK && i_status.all_done) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_status.hold_valid) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/srs_datapath.sv
// Datapath: configuration, window bookkeeping, slot timers and the result registers.
module srs_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  srs_pkg::t_cmd                   i_cmd,
    input  srs_pkg::t_in_item               i_in,
    input  logic                            i_cfg_valid,
    input  logic [1:0]                      i_cfg_index,
    input  logic [srs_pkg::TOT_W-1:0]       i_cfg_data,
    input  logic                            i_out_ready,
    output srs_pkg::t_status                o_status,
    output logic                            o_out_valid,
    output srs_pkg::t_out_item              o_out
);

    logic [srs_pkg::TOT_W-1:0] r_packet_total;
    logic [srs_pkg::WSZ_W-1:0] r_window_size;
    logic [srs_pkg::TMO_W-1:0] r_timeout;

    logic [srs_pkg::IDX_W-1:0] r_run_total;
    logic [srs_pkg::WIN_W-1:0] r_run_window;
    logic [srs_pkg::IDX_W-1:0] r_base;
    logic [srs_pkg::IDX_W-1:0] r_next;
    logic [srs_pkg::IDX_W-1:0] r_scan;
    logic                      r_running;
    logic [srs_pkg::MAX_WINDOW-1:0] r_acked;
    logic [srs_pkg::TMO_W-1:0] r_timer [srs_pkg::MAX_WINDOW];

    srs_pkg::t_req_e           r_req;
    logic [srs_pkg::PKT_W-1:0] r_num;

    logic                      r_hold_valid;
    srs_pkg::t_out_item        r_hold;
    logic                      r_out_valid;
    srs_pkg::t_out_item        r_out;

    logic [srs_pkg::IDX_W-1:0]  w_idx;
    logic [srs_pkg::SLOT_W-1:0] w_idx_slot;
    logic [srs_pkg::SLOT_W-1:0] w_scan_slot;
    logic [srs_pkg::SLOT_W-1:0] w_base_slot;
    logic [srs_pkg::SLOT_W-1:0] w_next_slot;
    logic [srs_pkg::IDX_W:0]    w_win_end;
    logic [srs_pkg::TMO_W-1:0]  w_reload;
    logic [srs_pkg::IDX_W-1:0]  w_sat_total;
    logic [srs_pkg::WIN_W-1:0]  w_sat_window;
    logic                       w_scan_expire;
    logic                       w_scan_send;
    logic                       w_emit;
    srs_pkg::t_out_item         w_new;

    assign w_idx       = srs_pkg::IDX_W'(r_num) - srs_pkg::IDX_W'(1);
    assign w_idx_slot  = w_idx[srs_pkg::SLOT_W-1:0];
    assign w_scan_slot = r_scan[srs_pkg::SLOT_W-1:0];
    assign w_base_slot = r_base[srs_pkg::SLOT_W-1:0];
    assign w_next_slot = r_next[srs_pkg::SLOT_W-1:0];
    assign w_win_end   = {1'b0, r_base} + (srs_pkg::IDX_W + 1)'(r_run_window);
    assign w_reload    = (r_timeout == '0) ? srs_pkg::TMO_W'(1) : r_timeout;

    always_comb begin
        if (r_packet_total == '0) begin
            w_sat_total = srs_pkg::IDX_W'(1);
        end else if ((srs_pkg::TOT_W + 1)'(r_packet_total) >
                     (srs_pkg::TOT_W + 1)'(srs_pkg::MAX_PACKETS)) begin
            w_sat_total = srs_pkg::IDX_W'(srs_pkg::MAX_PACKETS);
        end else begin
            w_sat_total = srs_pkg::IDX_W'(r_packet_total);
        end
        if (r_window_size == '0) begin
            w_sat_window = srs_pkg::WIN_W'(1);
        end else if ((srs_pkg::WSZ_W + 8)'(r_window_size) >
                     (srs_pkg::WSZ_W + 8)'(srs_pkg::W_LIMIT)) begin
            w_sat_window = srs_pkg::WIN_W'(srs_pkg::W_LIMIT);
        end else begin
            w_sat_window = srs_pkg::WIN_W'(r_window_size);
        end
    end

    assign w_scan_expire = (r_timer[w_scan_slot] <= srs_pkg::TMO_W'(1));
    assign w_scan_send   = i_cmd.scan_step && !r_acked[w_scan_slot] && w_scan_expire;
    assign w_emit        = w_scan_send || i_cmd.nack_send || i_cmd.admit_step
                         || i_cmd.emit_done;

    always_comb begin
        w_new             = '0;
        w_new.last_of_run = 1'b0;
        priority if (w_scan_send) begin
            w_new.event_kind = srs_pkg::EV_TIMEOUT;
            w_new.packet_id  = srs_pkg::PKT_W'(r_scan) + srs_pkg::PKT_W'(1);
        end else if (i_cmd.nack_send) begin
            w_new.event_kind = srs_pkg::EV_NACK;
            w_new.packet_id  = r_num;
        end else if (i_cmd.admit_step) begin
            w_new.event_kind = srs_pkg::EV_FIRST;
            w_new.packet_id  = srs_pkg::PKT_W'(r_next) + srs_pkg::PKT_W'(1);
        end else begin
            w_new.event_kind = srs_pkg::EV_DONE;
            w_new.packet_id  = '0;
        end
    end

    // Status towards the controller.
    always_comb begin
        o_status             = '0;
        o_status.req         = r_req;
        o_status.running     = r_running;
        o_status.ref_ok      = (r_num != '0)
                             && ((srs_pkg::PKT_W + 1)'(r_num) <= (srs_pkg::PKT_W + 1)'(r_run_total))
                             && (w_idx >= r_base) && (w_idx < r_next)
                             && !r_acked[w_idx_slot];
        o_status.idx_is_base = (w_idx == r_base);
        o_status.scan_more   = (r_scan < r_next);
        o_status.slide_more  = (r_base < r_next) && r_acked[w_base_slot];
        o_status.admit_more  = (r_next < r_run_total) && ({1'b0, r_next} < w_win_end);
        o_status.all_done    = (r_base >= r_run_total);
        o_status.hold_valid  = r_hold_valid;
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    // Configuration registers and run control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_total <= srs_pkg::TOT_W'(5);
            r_window_size  <= srs_pkg::WSZ_W'(3);
            r_timeout      <= srs_pkg::TMO_W'(5);
            r_run_total    <= '0;
            r_run_window   <= '0;
            r_base         <= '0;
            r_next         <= '0;
            r_scan         <= '0;
            r_running      <= 1'b0;
            r_acked        <= '0;
            r_req          <= srs_pkg::REQ_TICK;
            r_hold_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    srs_pkg::CFG_PACKET_TOTAL:  r_packet_total <= i_cfg_data;
                    srs_pkg::CFG_WINDOW_SIZE:   r_window_size  <= i_cfg_data[srs_pkg::WSZ_W-1:0];
                    srs_pkg::CFG_TIMEOUT_TICKS: r_timeout      <= i_cfg_data[srs_pkg::TMO_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.latch) begin
                r_req <= srs_pkg::t_req_e'(i_in.req_type);
            end

            if (i_cmd.start_run) begin
                r_run_total  <= w_sat_total;
                r_run_window <= w_sat_window;
                r_base       <= '0;
                r_next       <= '0;
                r_running    <= 1'b1;
                r_acked      <= '0;
            end
            if (i_cmd.scan_init) begin
                r_scan <= r_base;
            end
            if (i_cmd.scan_step) begin
                r_scan <= r_scan + srs_pkg::IDX_W'(1);
            end
            if (i_cmd.mark_ack) begin
                r_acked[w_idx_slot] <= 1'b1;
            end
            if (i_cmd.slide_step) begin
                r_base <= r_base + srs_pkg::IDX_W'(1);
            end
            if (i_cmd.admit_step) begin
                r_acked[w_next_slot] <= 1'b0;
                r_next               <= r_next + srs_pkg::IDX_W'(1);
            end
            if (i_cmd.emit_done) begin
                r_running <= 1'b0;
            end

            // Result staging: the newest result waits in the hold register so
            // that the final one of a request can be flagged.
            if (i_cmd.finish || (w_emit && r_hold_valid)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_emit) begin
                r_hold_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_num <= i_in.packet_number;
        end
        if (w_emit) begin
            r_hold <= w_new;
        end
        if (i_cmd.finish) begin
            r_out <= {r_hold.event_kind, r_hold.packet_id, 1'b1};
        end else if (w_emit && r_hold_valid) begin
            r_out <= r_hold;
        end
    end

    // Retransmit timers, one per slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < srs_pkg::MAX_WINDOW; s++) begin
                r_timer[s] <= '0;
            end
        end else begin
            if (i_cmd.start_run) begin
                for (int s = 0; s < srs_pkg::MAX_WINDOW; s++) begin
                    r_timer[s] <= '0;
                end
            end
            if (i_cmd.scan_step && !r_acked[w_scan_slot]) begin
                r_timer[w_scan_slot] <= w_scan_expire ? w_reload
                                      : r_timer[w_scan_slot] - srs_pkg::TMO_W'(1);
            end
            if (i_cmd.nack_send) begin
                r_timer[w_idx_slot] <= w_reload;
            end
            if (i_cmd.admit_step) begin
                r_timer[w_next_slot] <= w_reload;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: src/selective_repeat_sender.sv
// Selective-repeat ARQ sender. One request beat is worked at a time: accept, decode, then
// each walk (timer scan, window slide, admission) steps through its entries and then leaves,
// with a done step where it applies, then finish. The next beat is taken only once the
// current one is through; output stalls hold every step that emits a result.
// Reset is synchronous and active low; it restores the default configuration and idles.
module selective_repeat_sender (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  srs_pkg::t_in_item         i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output srs_pkg::t_out_item        o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [srs_pkg::TOT_W-1:0] i_cfg_data
);

    // The controller steps through the work of each request beat; the
    // datapath owns every stored value and reports conditions back.
    // Acknowledged bits are kept per timer slot: only packets inside the
    // window are ever looked up, and the window never exceeds the slot count,
    // so each admitted packet clears its slot's bit when first sent.
    // Results pass through a hold register, so the final result of a request
    // can carry its last-of-run flag, and then an output register that lets
    // the next request beat be accepted while a result still waits.

    srs_pkg::t_cmd    w_cmd;
    srs_pkg::t_status w_status;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    srs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    srs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
